### rtl/sffh_pkg.sv
// sffh_pkg: shared types, constants and register codes of the stereo frame fifo
// used by sffh_cfg, sffh_front, sffh_back and the top level; depends on nothing

package sffh_pkg;

    // default sizes, handed to the top level parameters
    localparam int QUEUE_FRAMES_DEF = 8192;
    localparam int CHUNK_FRAMES_DEF = 32;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = 2 * SAMPLE_W;
    localparam int COUNT_W    = 32;
    localparam int THR_W      = 13;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [THR_W-1:0] PRIME_DEFAULT = THR_W'(4096);

    // command queue and output buffer sizes
    localparam int CMDQ_DEPTH = 2;
    localparam int OBUF_DEPTH = 4;

    // input action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_ENABLE    = 1'b0,
        REG_PRIME_THR = 1'b1
    } t_reg_idx;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // configuration seen by the datapath
    typedef struct packed {
        logic             enable;
        logic [THR_W-1:0] prime_thr;
        logic             clear;     // one-cycle pulse when the block is switched on
    } t_cfg;

    // classified command from the front to the back
    typedef struct packed {
        logic    is_pop;
        t_sample left;
        t_sample right;
    } t_cmd;

    // tag riding with a frame slot while the store read is in flight
    typedef struct packed {
        logic               fill;
        logic               last;
        logic               hold_upd;
        logic [COUNT_W-1:0] dropped;
        logic [COUNT_W-1:0] under;
    } t_ret_tag;

    // one emitted frame
    typedef struct packed {
        t_sample            left;
        t_sample            right;
        logic               filled;
        logic               last;
        logic [COUNT_W-1:0] dropped;
        logic [COUNT_W-1:0] under;
    } t_result;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } t_back_state;

endpackage

### rtl/sffh_if.sv
// sffh_in_if and sffh_out_if: valid/ready channels of the stereo frame fifo
// plain interfaces with fixed field widths; no package dependency

interface sffh_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;

    modport source (output valid, action, left_in, right_in, input ready);
    modport sink   (input valid, action, left_in, right_in, output ready);
endinterface

interface sffh_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               filled;
    logic               last_of_chunk;
    logic [31:0]        dropped_total;
    logic [31:0]        underrun_total;

    modport source (output valid, left_out, right_out, filled, last_of_chunk,
                    dropped_total, underrun_total, input ready);
    modport sink   (input valid, left_out, right_out, filled, last_of_chunk,
                    dropped_total, underrun_total, output ready);
endinterface

### rtl/sffh_ram.sv
// sffh_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module sffh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sffh_cfg.sv
// sffh_cfg: apb register file holding enable and prime threshold
// depends on sffh_pkg

module sffh_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sffh_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sffh_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sffh_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output sffh_pkg::t_cfg                    o_cfg
);
    import sffh_pkg::*;

    logic             r_enable, n_enable;
    logic [THR_W-1:0] r_prime_thr, n_prime_thr;
    logic             wr_en;
    logic             clear;
    t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    // register write decode
    always_comb begin
        n_enable    = r_enable;
        n_prime_thr = r_prime_thr;
        clear       = 1'b0;
        if (wr_en) begin
            unique case (reg_idx)
                REG_ENABLE: begin
                    n_enable = pwdata[0];
                    clear    = pwdata[0] & ~r_enable;
                end
                REG_PRIME_THR: begin
                    n_prime_thr = pwdata[THR_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_prime_thr <= PRIME_DEFAULT;
        end else begin
            r_enable    <= n_enable;
            r_prime_thr <= n_prime_thr;
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_ENABLE:    prdata = APB_DATA_W'(r_enable);
            REG_PRIME_THR: prdata = APB_DATA_W'(r_prime_thr);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.enable    = r_enable;
    assign o_cfg.prime_thr = r_prime_thr;
    assign o_cfg.clear     = clear;

endmodule

### rtl/sffh_front.sv
// sffh_front: accepts input items, classifies them and queues commands for the back
// depends on sffh_pkg and sffh_in_if

module sffh_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sffh_in_if.sink        i_in,
    input  sffh_pkg::t_cfg i_cfg,
    output sffh_pkg::t_cmd o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready
);
    import sffh_pkg::*;

    localparam int QAW = $clog2(CMDQ_DEPTH);
    localparam int QCW = $clog2(CMDQ_DEPTH + 1);

    t_cmd           r_q [CMDQ_DEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_cnt, n_cnt;
    logic           accept;
    logic           enq;
    logic           deq;
    t_cmd           cmd_in;

    // classify: items taken while disabled are swallowed
    assign i_in.ready = (r_cnt != QCW'(CMDQ_DEPTH));
    assign accept     = i_in.valid & i_in.ready;
    assign enq        = accept & i_cfg.enable;
    assign deq        = o_cmd_valid & i_cmd_ready;

    assign cmd_in.is_pop = (i_in.action == ACT_POP);
    assign cmd_in.left   = i_in.left_in;
    assign cmd_in.right  = i_in.right_in;

    always_comb begin
        n_cnt = r_cnt;
        if (enq && !deq) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (!enq && deq) begin
            n_cnt = r_cnt - QCW'(1);
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (enq) begin
                r_wr <= (r_wr == QAW'(CMDQ_DEPTH - 1)) ? '0 : r_wr + QAW'(1);
            end
            if (deq) begin
                r_rd <= (r_rd == QAW'(CMDQ_DEPTH - 1)) ? '0 : r_rd + QAW'(1);
            end
        end
    end

    // queue entries
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr] <= cmd_in;
        end
    end

    assign o_cmd       = r_q[r_rd];
    assign o_cmd_valid = (r_cnt != '0);

endmodule

### rtl/sffh_back.sv
// sffh_back: executes queued commands on the frame store and streams chunks
// depends on sffh_pkg, sffh_out_if and sffh_ram

module sffh_back #(
    parameter int QUEUE_FRAMES = sffh_pkg::QUEUE_FRAMES_DEF,
    parameter int CHUNK_FRAMES = sffh_pkg::CHUNK_FRAMES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sffh_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  sffh_pkg::t_cfg i_cfg,
    sffh_out_if.source     o_out
);
    import sffh_pkg::*;

    localparam int AW  = $clog2(QUEUE_FRAMES);
    localparam int CW  = $clog2(CHUNK_FRAMES + 1);
    localparam int OAW = $clog2(OBUF_DEPTH);
    localparam int OCW = $clog2(OBUF_DEPTH + 1);

    localparam logic [AW-1:0] LAST_SLOT  = AW'(QUEUE_FRAMES - 1);
    localparam logic [CW-1:0] CHUNK_CNT  = CW'(CHUNK_FRAMES);
    localparam logic [CW-1:0] LAST_FRAME = CW'(CHUNK_FRAMES - 1);

    t_back_state r_state, n_state;

    logic [AW-1:0]      r_wr_idx, n_wr_idx;
    logic [AW-1:0]      r_rd_idx, n_rd_idx;
    logic [AW-1:0]      r_depth, n_depth;
    logic               r_primed, n_primed;
    logic [COUNT_W-1:0] r_drop_cnt, n_drop_cnt;
    logic [COUNT_W-1:0] r_under_cnt, n_under_cnt;
    t_sample            r_hold_l, n_hold_l;
    t_sample            r_hold_r, n_hold_r;
    logic [CW-1:0]      r_frame, n_frame;
    logic [CW-1:0]      r_avail, n_avail;
    logic [COUNT_W-1:0] r_chunk_drop, n_chunk_drop;
    logic [COUNT_W-1:0] r_chunk_under, n_chunk_under;

    // read return stage
    logic     r_ret_valid;
    t_ret_tag r_ret_tag;
    t_ret_tag issue_tag;

    // output buffer
    t_result        r_ob [OBUF_DEPTH];
    logic [OAW-1:0] r_ob_wr, r_ob_rd;
    logic [OCW-1:0] r_ob_cnt, n_ob_cnt;
    logic           ob_pop;
    t_result        ret_res;

    // frame store ports
    logic               ram_we;
    logic [FRAME_W-1:0] ram_wdata;
    logic               ram_re;
    logic [FRAME_W-1:0] ram_rdata;

    logic               fifo_full;
    logic               pop_go;
    logic [CW-1:0]      avail_start;
    logic [CW-1:0]      short_by;
    logic [COUNT_W:0]   under_sum;
    logic [COUNT_W-1:0] under_next;
    logic [COUNT_W:0]   drop_sum;
    logic               can_issue;
    logic               issue;
    logic               is_fill;
    logic               is_last;

    sffh_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (QUEUE_FRAMES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // left sample in the low half, right in the high half
    assign ram_wdata = {i_cmd.right, i_cmd.left};

    // pop start: priming test, chunk split and underrun total
    assign fifo_full   = (r_depth == LAST_SLOT);
    assign pop_go      = r_primed || (32'(r_depth) >= 32'(i_cfg.prime_thr));
    assign avail_start = (32'(r_depth) >= 32'(CHUNK_FRAMES)) ? CHUNK_CNT : CW'(r_depth);
    assign short_by    = CHUNK_CNT - avail_start;
    assign under_sum   = {1'b0, r_under_cnt} + (COUNT_W + 1)'(short_by);
    assign under_next  = under_sum[COUNT_W] ? '1 : under_sum[COUNT_W-1:0];
    assign drop_sum    = {1'b0, r_drop_cnt} + (COUNT_W + 1)'(1);

    // frame slot issue, held back while the output buffer could overflow
    assign can_issue = (OCW'(r_ob_cnt) + OCW'(r_ret_valid)) < OCW'(OBUF_DEPTH);
    assign issue     = (r_state == ST_STREAM) && can_issue;
    assign is_fill   = (r_frame >= r_avail);
    assign is_last   = (r_frame == LAST_FRAME);
    assign ram_re    = issue && !is_fill;

    assign issue_tag.fill     = is_fill;
    assign issue_tag.last     = is_last;
    assign issue_tag.hold_upd = is_last && (r_avail == CHUNK_CNT);
    assign issue_tag.dropped  = r_chunk_drop;
    assign issue_tag.under    = r_chunk_under;

    assign o_cmd_ready = (r_state == ST_IDLE);

    // command sequencer
    always_comb begin
        n_state       = r_state;
        n_wr_idx      = r_wr_idx;
        n_rd_idx      = r_rd_idx;
        n_depth       = r_depth;
        n_primed      = r_primed;
        n_drop_cnt    = r_drop_cnt;
        n_under_cnt   = r_under_cnt;
        n_frame       = r_frame;
        n_avail       = r_avail;
        n_chunk_drop  = r_chunk_drop;
        n_chunk_under = r_chunk_under;
        ram_we        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (!i_cmd.is_pop) begin
                        if (fifo_full) begin
                            n_drop_cnt = drop_sum[COUNT_W] ? '1 : drop_sum[COUNT_W-1:0];
                        end else begin
                            ram_we   = 1'b1;
                            n_wr_idx = (r_wr_idx == LAST_SLOT) ? '0 : r_wr_idx + AW'(1);
                            n_depth  = r_depth + AW'(1);
                        end
                    end else if (pop_go) begin
                        n_primed      = 1'b1;
                        n_under_cnt   = under_next;
                        n_chunk_under = under_next;
                        n_chunk_drop  = r_drop_cnt;
                        n_avail       = avail_start;
                        n_frame       = '0;
                        n_state       = ST_STREAM;
                    end
                end
            end
            ST_STREAM: begin
                if (issue) begin
                    n_frame = r_frame + CW'(1);
                    if (!is_fill) begin
                        n_rd_idx = (r_rd_idx == LAST_SLOT) ? '0 : r_rd_idx + AW'(1);
                        n_depth  = r_depth - AW'(1);
                    end
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // switching the block on restarts priming and the counters
        if (i_cfg.clear) begin
            n_primed    = 1'b0;
            n_drop_cnt  = '0;
            n_under_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_depth     <= '0;
            r_primed    <= 1'b0;
            r_drop_cnt  <= '0;
            r_under_cnt <= '0;
            r_frame     <= '0;
            r_avail     <= '0;
            r_ret_valid <= 1'b0;
        end else begin
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_depth     <= n_depth;
            r_primed    <= n_primed;
            r_drop_cnt  <= n_drop_cnt;
            r_under_cnt <= n_under_cnt;
            r_frame     <= n_frame;
            r_avail     <= n_avail;
            r_ret_valid <= issue;
        end
    end

    // per-chunk totals and the in-flight tag
    always_ff @(posedge i_clk) begin
        r_chunk_drop  <= n_chunk_drop;
        r_chunk_under <= n_chunk_under;
        if (issue) begin
            r_ret_tag <= issue_tag;
        end
    end

    // read return: fill frames take the held frame, a full chunk's last frame refreshes it
    always_comb begin
        n_hold_l = r_hold_l;
        n_hold_r = r_hold_r;
        if (r_ret_valid && r_ret_tag.hold_upd) begin
            n_hold_l = ram_rdata[SAMPLE_W-1:0];
            n_hold_r = ram_rdata[FRAME_W-1:SAMPLE_W];
        end
        if (i_cfg.clear) begin
            n_hold_l = '0;
            n_hold_r = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_l <= '0;
            r_hold_r <= '0;
        end else begin
            r_hold_l <= n_hold_l;
            r_hold_r <= n_hold_r;
        end
    end

    assign ret_res.left    = r_ret_tag.fill ? r_hold_l : t_sample'(ram_rdata[SAMPLE_W-1:0]);
    assign ret_res.right   = r_ret_tag.fill ? r_hold_r
                                            : t_sample'(ram_rdata[FRAME_W-1:SAMPLE_W]);
    assign ret_res.filled  = r_ret_tag.fill;
    assign ret_res.last    = r_ret_tag.last;
    assign ret_res.dropped = r_ret_tag.dropped;
    assign ret_res.under   = r_ret_tag.under;

    // output buffer
    assign ob_pop = o_out.valid & o_out.ready;

    always_comb begin
        n_ob_cnt = r_ob_cnt;
        if (r_ret_valid && !ob_pop) begin
            n_ob_cnt = r_ob_cnt + OCW'(1);
        end else if (!r_ret_valid && ob_pop) begin
            n_ob_cnt = r_ob_cnt - OCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wr  <= '0;
            r_ob_rd  <= '0;
            r_ob_cnt <= '0;
        end else begin
            r_ob_cnt <= n_ob_cnt;
            if (r_ret_valid) begin
                r_ob_wr <= r_ob_wr + OAW'(1);
            end
            if (ob_pop) begin
                r_ob_rd <= r_ob_rd + OAW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ret_valid) begin
            r_ob[r_ob_wr] <= ret_res;
        end
    end

    assign o_out.valid          = (r_ob_cnt != '0);
    assign o_out.left_out       = r_ob[r_ob_rd].left;
    assign o_out.right_out      = r_ob[r_ob_rd].right;
    assign o_out.filled         = r_ob[r_ob_rd].filled;
    assign o_out.last_of_chunk  = r_ob[r_ob_rd].last;
    assign o_out.dropped_total  = r_ob[r_ob_rd].dropped;
    assign o_out.underrun_total = r_ob[r_ob_rd].under;

endmodule

### rtl/stereo_frame_fifo_with_prime_and_hold_unit.sv
// stereo_frame_fifo_with_prime_and_hold_unit: top level of the stereo frame fifo
// depends on sffh_pkg, sffh_if, sffh_cfg, sffh_front and sffh_back
//
//  channel   dir  kind         carries
//  i_in      in   valid/ready  action, left_in, right_in
//  o_out     out  valid/ready  left_out, right_out, filled, last_of_chunk, totals
//  apb       in   apb rd/wr    enable (0x0), prime_threshold (0x4)
//
// a push is done in the back while it is idle, so pushes stream at one item per cycle
// unless a chunk is streaming. a pop moves the back to streaming, which issues one
// frame slot per cycle while the output buffer has room, set by the single read port
// of the frame store; the next item waits in a two-entry command queue meanwhile.
// synchronous active-low reset; the frame store itself is not cleared.
// a full four-entry output buffer stalls frame issue; a full command queue drops i_in.ready.

module stereo_frame_fifo_with_prime_and_hold_unit #(
    parameter int QUEUE_FRAMES = sffh_pkg::QUEUE_FRAMES_DEF,
    parameter int CHUNK_FRAMES = sffh_pkg::CHUNK_FRAMES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sffh_in_if.sink                         i_in,
    sffh_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sffh_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sffh_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sffh_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import sffh_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_ready;

    // configuration registers
    sffh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // accept and classify
    sffh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (cfg),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready)
    );

    // store, chunk streaming and counters
    sffh_back #(
        .QUEUE_FRAMES (QUEUE_FRAMES),
        .CHUNK_FRAMES (CHUNK_FRAMES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cfg       (cfg),
        .o_out       (o_out)
    );

endmodule

### sim/stereo_frame_fifo_with_prime_and_hold_unit_tb.sv
// testbench of the stereo frame fifo: random and directed push/pop items, apb setup,
// frame-by-frame check of every emitted chunk against a built-in fifo model
// depends on sffh_pkg, sffh_if and stereo_frame_fifo_with_prime_and_hold_unit

module stereo_frame_fifo_with_prime_and_hold_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sffh_pkg::*;

    localparam int QDEPTH           = QUEUE_FRAMES_DEF;
    localparam int CHUNK            = CHUNK_FRAMES_DEF;
    localparam int IDX_W            = $clog2(QDEPTH);
    localparam int SETTLE_CYCLES    = 2 * CHUNK + 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RUN_LIMIT_NS     = 1_000_000;

    typedef struct packed {
        logic    action;
        t_sample left;
        t_sample right;
    } frame_cmd_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // channel drive registers, known from time zero
    logic    cmd_valid  = 1'b0;
    logic    cmd_action = ACT_PUSH;
    t_sample cmd_left   = '0;
    t_sample cmd_right  = '0;
    logic    out_ready  = 1'b0;

    sffh_in_if  cmd_ch();
    sffh_out_if frame_ch();

    assign cmd_ch.valid    = cmd_valid;
    assign cmd_ch.action   = cmd_action;
    assign cmd_ch.left_in  = cmd_left;
    assign cmd_ch.right_in = cmd_right;
    assign frame_ch.ready  = out_ready;

    stereo_frame_fifo_with_prime_and_hold_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (frame_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // fifo model state
    logic [FRAME_W-1:0] ring_mem [QDEPTH];
    logic [IDX_W-1:0]   rd_ptr;
    logic [IDX_W-1:0]   wr_ptr;
    logic               primed_q;
    t_sample            held_left;
    t_sample            held_right;
    logic [COUNT_W-1:0] drops;
    logic [COUNT_W-1:0] underruns;
    logic               en_q;
    logic [THR_W-1:0]   thr_q;

    frame_cmd_t cmd_pending_q[$];
    t_result    frame_expect_q[$];

    int mismatch_cnt  = 0;
    int send_idle_pct = 13;
    int recv_idle_pct = 83;
    int stall_ticket  = 0;
    int ticket_seen   = 0;
    int hold_remaining = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    endtask

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input int unsigned b);
        logic [COUNT_W:0] sum;
        sum = {1'b0, a} + (COUNT_W + 1)'(b);
        return sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
    endfunction

    // fifo model: one accepted item in, its emitted frames appended to the expect queue
    function automatic void fifo_model_accept(input frame_cmd_t cmd);
        logic [IDX_W-1:0]   depth_now;
        int unsigned        avail;
        logic [FRAME_W-1:0] word;
        t_result            fr;
        if (!en_q)
            return;
        depth_now = wr_ptr - rd_ptr;
        if (cmd.action == ACT_PUSH) begin
            if (depth_now == IDX_W'(QDEPTH - 1)) begin
                drops = sat_add(drops, 1);
            end else begin
                ring_mem[wr_ptr] = {cmd.right, cmd.left};
                wr_ptr = wr_ptr + 1'b1;
            end
            return;
        end
        if (!primed_q) begin
            if (32'(depth_now) < 32'(thr_q))
                return;
            primed_q = 1'b1;
        end
        avail = (32'(depth_now) < CHUNK) ? 32'(depth_now) : CHUNK;
        underruns = sat_add(underruns, CHUNK - avail);
        for (int i = 0; i < CHUNK; i++) begin
            fr.filled = (i >= avail);
            if (!fr.filled) begin
                word   = ring_mem[rd_ptr];
                rd_ptr = rd_ptr + 1'b1;
                fr.left  = word[SAMPLE_W-1:0];
                fr.right = word[FRAME_W-1:SAMPLE_W];
                // a complete chunk refreshes the held frame
                if (avail == CHUNK && i == CHUNK - 1) begin
                    held_left  = fr.left;
                    held_right = fr.right;
                end
            end else begin
                fr.left  = held_left;
                fr.right = held_right;
            end
            fr.last    = (i == CHUNK - 1);
            fr.dropped = drops;
            fr.under   = underruns;
            frame_expect_q.push_back(fr);
        end
    endfunction

    // item driver: predicts on acceptance, then offers the next pending item
    always @(posedge i_clk) begin
        frame_cmd_t taken;
        frame_cmd_t nxt;
        if (!i_rst_n) begin
            cmd_valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                taken.action = cmd_ch.action;
                taken.left   = cmd_ch.left_in;
                taken.right  = cmd_ch.right_in;
                fifo_model_accept(taken);
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (cmd_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = cmd_pending_q.pop_front();
                    cmd_valid  <= 1'b1;
                    cmd_action <= nxt.action;
                    cmd_left   <= nxt.left;
                    cmd_right  <= nxt.right;
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // frame receiver: random stalls, plus a long hold-off when a new ticket shows up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_ticket != ticket_seen) begin
            ticket_seen    = stall_ticket;
            hold_remaining = LONG_HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_remaining > 0) begin
            hold_remaining--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // frame monitor: every accepted frame against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && frame_ch.valid && frame_ch.ready) begin
            if (frame_expect_q.size() == 0) begin
                report_mismatch("unexpected frame", {frame_ch.right_out, frame_ch.left_out}, 0);
            end else begin
                want = frame_expect_q.pop_front();
                if (frame_ch.left_out !== want.left)
                    report_mismatch("left_out", 32'(frame_ch.left_out), 32'(want.left));
                if (frame_ch.right_out !== want.right)
                    report_mismatch("right_out", 32'(frame_ch.right_out), 32'(want.right));
                if (frame_ch.filled !== want.filled)
                    report_mismatch("filled", 32'(frame_ch.filled), 32'(want.filled));
                if (frame_ch.last_of_chunk !== want.last)
                    report_mismatch("last_of_chunk", 32'(frame_ch.last_of_chunk),
                                    32'(want.last));
                if (frame_ch.dropped_total !== want.dropped)
                    report_mismatch("dropped_total", frame_ch.dropped_total, want.dropped);
                if (frame_ch.underrun_total !== want.under)
                    report_mismatch("underrun_total", frame_ch.underrun_total, want.under);
            end
        end
    end

    task automatic queue_push(input t_sample l, input t_sample r);
        frame_cmd_t c;
        c.action = ACT_PUSH;
        c.left   = l;
        c.right  = r;
        cmd_pending_q.push_back(c);
    endtask

    task automatic queue_pop();
        frame_cmd_t c;
        c.action = ACT_POP;
        c.left   = t_sample'($urandom);
        c.right  = t_sample'($urandom);
        cmd_pending_q.push_back(c);
    endtask

    task automatic queue_random_push();
        queue_push(t_sample'($urandom), t_sample'($urandom));
    endtask

    // wait for every item taken and every frame seen, then let the back end settle
    task automatic wait_idle();
        while (cmd_pending_q.size() != 0 || cmd_ch.valid || frame_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // apb write with junk in the unused upper bits, then a readback
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] wdata;
        logic [31:0] want_rd;
        if (idx == REG_ENABLE)
            wdata = value | ($urandom & ~32'h1);
        else
            wdata = value | ($urandom & ~32'((1 << THR_W) - 1));
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // register written at this edge
        if (idx == REG_ENABLE) begin
            if (wdata[0] && !en_q) begin
                drops      = '0;
                underruns  = '0;
                primed_q   = 1'b0;
                held_left  = '0;
                held_right = '0;
            end
            en_q    = wdata[0];
            want_rd = 32'(en_q);
        end else begin
            thr_q   = wdata[THR_W-1:0];
            want_rd = 32'(thr_q);
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want_rd)
            report_mismatch("register readback", prdata, want_rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // mostly bursts of pushes closed by a pop, with lone pops and loose pushes mixed in
    task automatic queue_random_traffic(input int n_items);
        int added;
        int burst;
        int pick;
        added = 0;
        while (added < n_items) begin
            pick = $urandom_range(9);
            if (pick <= 6) begin
                burst = $urandom_range(1, 40);
                repeat (burst) queue_random_push();
                queue_pop();
                added += burst + 1;
            end else if (pick == 7) begin
                queue_pop();
                added++;
            end else if (pick == 8) begin
                queue_pop();
                queue_pop();
                added += 2;
            end else begin
                burst = $urandom_range(1, 8);
                repeat (burst) queue_random_push();
                added += burst;
            end
        end
    endtask

    // watchdog
    initial begin
        #RUN_LIMIT_NS;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        rd_ptr     = '0;
        wr_ptr     = '0;
        primed_q   = 1'b0;
        held_left  = '0;
        held_right = '0;
        drops      = '0;
        underruns  = '0;
        en_q       = 1'b0;
        thr_q      = PRIME_DEFAULT;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first profile: sender mostly busy, receiver mostly stalled
        send_idle_pct = 13;
        recv_idle_pct = 83;

        // disabled after reset: both kinds of item are ignored
        queue_push(16'sh1234, -16'sh0567);
        queue_pop();
        wait_idle();

        // zero threshold primes on the first pop, empty fifo gives a chunk of zero fill
        write_reg(REG_PRIME_THR, 32'd0);
        write_reg(REG_ENABLE, 32'd1);
        queue_pop();
        // sample extremes, then a short chunk padded with fill
        queue_push(16'sh8000, 16'sh7FFF);
        queue_push(16'sh7FFF, 16'sh8000);
        queue_push(16'sh8000, 16'sh8000);
        queue_push(16'sh7FFF, 16'sh7FFF);
        queue_push(16'sh0000, 16'shFFFF);
        queue_push(16'shFFFF, 16'sh0000);
        queue_pop();
        wait_idle();

        // off keeps the fifo, pushes while off are not counted
        write_reg(REG_ENABLE, 32'd0);
        queue_push(16'sh5555, 16'shAAAA);
        queue_pop();
        wait_idle();

        // back on clears counters and primed; pop below threshold gives nothing
        write_reg(REG_PRIME_THR, 32'd3);
        write_reg(REG_ENABLE, 32'd1);
        queue_push(16'sh0001, 16'sh0002);
        queue_push(16'sh0003, 16'sh0004);
        queue_pop();
        queue_push(16'sh0005, 16'sh0006);
        queue_pop();
        wait_idle();

        write_reg(REG_PRIME_THR, 32'($urandom_range(0, 40)));
        queue_random_traffic(30);
        wait_idle();

        // second profile: sender mostly idle, receiver mostly ready
        send_idle_pct = 83;
        recv_idle_pct = 13;
        write_reg(REG_ENABLE, 32'd0);
        repeat (6) begin
            if ($urandom_range(1))
                queue_pop();
            else
                queue_random_push();
        end
        wait_idle();
        write_reg(REG_PRIME_THR, 32'($urandom_range(0, 40)));
        write_reg(REG_ENABLE, 32'd1);
        queue_random_traffic(30);
        wait_idle();

        // third profile: no idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_PRIME_THR, 32'($urandom_range(0, 40)));
        queue_random_traffic(25);
        wait_idle();

        // receiver holds off for a long stretch while pops keep coming
        write_reg(REG_PRIME_THR, 32'd0);
        stall_ticket++;
        repeat (30) queue_random_push();
        repeat (6) queue_pop();
        wait_idle();

        if (frame_expect_q.size() != 0)
            report_mismatch("frames never emitted", frame_expect_q.size(), 0);
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/sffh_pkg.sv
rtl/sffh_if.sv
rtl/sffh_ram.sv
rtl/sffh_cfg.sv
rtl/sffh_front.sv
rtl/sffh_back.sv
rtl/stereo_frame_fifo_with_prime_and_hold_unit.sv
sim/stereo_frame_fifo_with_prime_and_hold_unit_tb.sv
